FILE: hw/rtl/lkv_pkg.sv
`default_nettype none

package lkv_pkg;

   // Request opcodes
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   // Register indexes on the control port
   localparam logic REG_CAPACITY = 1'b0;
   localparam int   CAP_W        = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Commit actions chosen by the controller
   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_READ   = 3'd1;
   localparam logic [2:0] ACT_UPDATE = 3'd2;
   localparam logic [2:0] ACT_INSERT = 3'd3;
   localparam logic [2:0] ACT_EVICT  = 3'd4;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
      logic               evicted;
      logic signed [31:0] evicted_key;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       match;
      logic       commit;
      logic [2:0] act;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_put;
      logic found;
      logic room;
   } ctrl_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/lru_key_value_cache.sv
// Flow: a request accepted while idle is captured, then passes through the lookup
// and commit states, and its response is registered on rsp_valid after the commit;
// busy stays high through lookup and commit, so a new request is taken only after the commit.
// The receiver cannot stall: each response is shown for exactly one cycle.
// Reset (synchronous, active high) clears all valid bits, ranks and the fill
// count at once and sets the capacity register to 16; no clearing pass is needed.
`default_nettype none

module lru_key_value_cache import lkv_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [CAP_W-1:0] cap_ff;
   logic             csr_write;
   ctrl_cmd_type     cmd;
   ctrl_status_type  status;

   // Register write on the access phase
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_write && paddr[2] == REG_CAPACITY) begin
         cap_ff <= pwdata[CAP_W-1:0];
      end
   end

   assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_ff} : '0;

   lkv_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   lkv_datapath #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .capacity  (cap_ff),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/lkv_datapath.sv
`default_nettype none

module lkv_datapath import lkv_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire ctrl_cmd_type    cmd,
   output ctrl_status_type      status,
   input  wire logic [CAP_W-1:0] capacity,
   input  wire req_type         req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // Entry table: keys are compared in parallel, so it stays in flops
   logic                valid_ff [ENTRIES];
   logic signed [31:0]  key_ff   [ENTRIES];
   logic signed [31:0]  value_ff [ENTRIES];
   logic [IDX_W-1:0]    rank_ff  [ENTRIES];
   logic [CNT_W-1:0]    count_ff;

   req_type             req_ff;
   logic [ENTRIES-1:0]  match_ff, match_in;
   logic [ENTRIES-1:0]  lru_ff, lru_in;
   logic                found_ff, room_ff;
   logic [CNT_W-1:0]    cap_eff;

   logic [ENTRIES-1:0]  fill_sel;
   logic [ENTRIES-1:0]  sel;
   logic [IDX_W-1:0]    old_rank;
   logic signed [31:0]  sel_key, sel_value;
   logic                was_valid;

   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff, rsp_data_in;

   // Clamp capacity into one to ENTRIES
   always_comb begin
      if (capacity == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(capacity) > 32'(ENTRIES)) begin
         cap_eff = CNT_W'(ENTRIES);
      end else begin
         cap_eff = CNT_W'(capacity);
      end
   end

   // Compare all keys; LRU entry holds the highest rank, count minus one
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (key_ff[i] == req_ff.key);
         lru_in[i]   = valid_ff[i] && (CNT_W'(rank_ff[i]) == count_ff - CNT_W'(1));
         fill_sel[i] = (CNT_W'(i) == count_ff);
      end
   end

   // Pick the entry that the commit acts on
   always_comb begin
      case (cmd.act)
         ACT_READ, ACT_UPDATE: sel = match_ff;
         ACT_INSERT:           sel = fill_sel;
         ACT_EVICT:            sel = lru_ff;
         default:              sel = '0;
      endcase
      old_rank  = '0;
      sel_key   = '0;
      sel_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (sel[i]) begin
            old_rank  = old_rank | rank_ff[i];
            sel_key   = sel_key | key_ff[i];
            sel_value = sel_value | value_ff[i];
         end
      end
      was_valid = (cmd.act != ACT_INSERT);
   end

   // Build the response
   always_comb begin
      rsp_data_in.hit         = found_ff;
      rsp_data_in.read_value  = (cmd.act == ACT_READ) ? sel_value : '0;
      rsp_data_in.evicted     = (cmd.act == ACT_EVICT);
      rsp_data_in.evicted_key = (cmd.act == ACT_EVICT) ? sel_key : '0;
   end

   // Capture the request and the lookup results
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.match) begin
         match_ff <= match_in;
         lru_ff   <= lru_in;
         found_ff <= |match_in;
         room_ff  <= (count_ff < cap_eff);
      end
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Update keys and values on commit
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (sel[i] && cmd.commit) begin
            if (cmd.act == ACT_INSERT || cmd.act == ACT_EVICT) begin
               key_ff[i] <= req_ff.key;
            end
            if (cmd.act != ACT_READ) begin
               value_ff[i] <= req_ff.value;
            end
         end
      end
   end

   // Valid bits, fill count, recency ranks
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end
      end else begin
         rsp_valid_ff <= cmd.commit;
         if (cmd.commit && cmd.act != ACT_NONE) begin
            if (cmd.act == ACT_INSERT) begin
               count_ff <= count_ff + CNT_W'(1);
            end
            for (int i = 0; i < ENTRIES; i++) begin
               if (sel[i]) begin
                  valid_ff[i] <= 1'b1;
                  rank_ff[i]  <= '0;
               end else if (valid_ff[i] && (!was_valid || rank_ff[i] < old_rank)) begin
                  rank_ff[i] <= rank_ff[i] + IDX_W'(1);
               end
            end
         end
      end
   end

   assign status.is_put = (req_ff.cmd == CMD_PUT);
   assign status.found  = found_ff;
   assign status.room   = room_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

   // Keys are unique, and ranks form a permutation, so at most one entry matches and the LRU pick is single
   a_match_onehot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $onehot0(match_ff))
      else $error("more than one entry matched the key");
   a_lru_onehot: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && count_ff != '0) |-> $onehot(lru_ff))
      else $error("LRU pick is not a single entry");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(ENTRIES))
      else $error("fill count exceeds the table");
   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.commit))
      else $error("response without a commit");

endmodule

`default_nettype wire

FILE: hw/rtl/lkv_controller.sv
`default_nettype none

module lkv_controller import lkv_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   output ctrl_cmd_type         cmd,
   input  wire ctrl_status_type status
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_MATCH  = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [2:0] act;

   // Choose what the commit does from the lookup outcome
   always_comb begin
      if (!status.is_put) begin
         act = status.found ? ACT_READ : ACT_NONE;
      end else if (status.found) begin
         act = ACT_UPDATE;
      end else if (status.room) begin
         act = ACT_INSERT;
      end else begin
         act = ACT_EVICT;
      end
   end

   // Advance idle, lookup, commit
   always_comb begin
      case (state_ff)
         S_IDLE:   state_in = start ? S_MATCH : S_IDLE;
         S_MATCH:  state_in = S_COMMIT;
         S_COMMIT: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign cmd.capture = (state_ff == S_IDLE) && start;
   assign cmd.match   = (state_ff == S_MATCH);
   assign cmd.commit  = (state_ff == S_COMMIT);
   assign cmd.act     = (state_ff == S_COMMIT) ? act : ACT_NONE;

   a_accept_to_match: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> state_ff == S_MATCH)
      else $error("accepted request did not enter lookup");
   a_commit_after_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COMMIT |-> $past(state_ff) == S_MATCH)
      else $error("commit without lookup");
   a_get_no_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !status.is_put) |-> (cmd.act == ACT_READ || cmd.act == ACT_NONE))
      else $error("get request chose a write action");

endmodule

`default_nettype wire

FILE: sim/tb_lru_key_value_cache.sv
`default_nettype none

module tb_lru_key_value_cache;
   import lkv_pkg::*;

   localparam int ENTRIES = 16;
   localparam logic [2:0] CAPACITY_ADDR = 3'(4 * int'(REG_CAPACITY));
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
   localparam int PHASES = 8;
   localparam int PHASE_REQUESTS = 210;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   req_type req_data = '0;
   logic busy;
   logic rsp_valid;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // Expected cache contents, mirrored request by request
   logic cached_valid [ENTRIES];
   logic signed [31:0] cached_key [ENTRIES];
   logic signed [31:0] cached_value [ENTRIES];
   logic [3:0] cached_rank [ENTRIES];
   logic [CAP_W-1:0] capacity_setting;

   req_type pending_req [$];
   rsp_type expected_rsp [$];
   logic signed [31:0] key_pool [$];

   int gap_pct = 0;
   int gap_left = 0;
   int mismatches = 0;
   int rsp_count = 0;
   int hit_count = 0;
   int evict_count = 0;
   int cap_writes = 0;

   always #5 clock = ~clock;

   lru_key_value_cache #(
      .ENTRIES(ENTRIES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // Make an entry most recent: valid entries ranked above it (all valid entries for a new one) move down one
   function automatic void promote(int idx, bit was_valid);
      logic [3:0] old_rank;
      old_rank = cached_rank[idx];
      for (int i = 0; i < ENTRIES; i++) begin
         if (i != idx && cached_valid[i] && (!was_valid || cached_rank[i] < old_rank)) begin
            cached_rank[i] = cached_rank[i] + 4'd1;
         end
      end
      cached_rank[idx] = '0;
   endfunction

   // Apply one request to the mirrored cache and return the response it gives
   function automatic rsp_type apply_request(req_type r);
      int unsigned cap;
      int unsigned count;
      int match_idx;
      int free_idx;
      int lru_idx;
      bit found;
      bit have_free;
      bit have_lru;
      logic [3:0] lru_rank;
      rsp_type res;
      cap = capacity_setting;
      if (cap == 0) cap = 1;
      if (cap > ENTRIES) cap = ENTRIES;
      count = 0;
      match_idx = 0;
      free_idx = 0;
      lru_idx = 0;
      found = 1'b0;
      have_free = 1'b0;
      have_lru = 1'b0;
      lru_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (cached_valid[i]) begin
            count++;
            if (!found && cached_key[i] == r.key) begin
               found = 1'b1;
               match_idx = i;
            end
            if (!have_lru || cached_rank[i] > lru_rank) begin
               have_lru = 1'b1;
               lru_idx = i;
               lru_rank = cached_rank[i];
            end
         end else if (!have_free) begin
            have_free = 1'b1;
            free_idx = i;
         end
      end
      res = '0;
      res.hit = found;
      if (r.cmd == CMD_GET) begin
         if (found) begin
            res.read_value = cached_value[match_idx];
            promote(match_idx, 1'b1);
         end
      end else if (found) begin
         cached_value[match_idx] = r.value;
         promote(match_idx, 1'b1);
      end else if (count < cap && have_free) begin
         cached_valid[free_idx] = 1'b1;
         cached_key[free_idx] = r.key;
         cached_value[free_idx] = r.value;
         promote(free_idx, 1'b0);
      end else if (have_lru) begin
         res.evicted = 1'b1;
         res.evicted_key = cached_key[lru_idx];
         cached_key[lru_idx] = r.key;
         cached_value[lru_idx] = r.value;
         promote(lru_idx, 1'b1);
      end
      return res;
   endfunction

   // Words biased toward the extremes
   function automatic logic signed [31:0] random_word();
      case ($urandom_range(11))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_request(logic cmd, logic signed [31:0] key, logic signed [31:0] value);
      req_type r;
      r.cmd = cmd;
      r.key = key;
      r.value = value;
      pending_req.push_back(r);
   endtask

   // Wait until every request is issued and every response has come back
   task automatic wait_idle();
      do @(negedge clock); while (pending_req.size() != 0 || start || expected_rsp.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Setup and access cycles on the register port
   task automatic write_capacity(logic [CAP_W-1:0] setting);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CAPACITY_ADDR;
      pwdata <= 32'(setting);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      capacity_setting = setting;
      cap_writes++;
   endtask

   // Issue requests from the pending queue, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (start && !busy) begin
         expected_rsp.push_back(apply_request(req_data));
         void'(pending_req.pop_front());
         if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            gap_left <= $urandom_range(13, 1);
         end else if (pending_req.size() != 0) begin
            req_data <= pending_req[0];
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_req.size() != 0) begin
            start <= 1'b1;
            req_data <= pending_req[0];
         end
      end
   end

   // Check each response against the oldest expectation
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid) begin
         rsp_count++;
         if (rsp_data.hit === 1'b1) hit_count++;
         if (rsp_data.evicted === 1'b1) evict_count++;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response with none expected: %p", rsp_data);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.hit !== want.hit || rsp_data.read_value !== want.read_value ||
                rsp_data.evicted !== want.evicted || rsp_data.evicted_key !== want.evicted_key) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("response %0d mismatch: expected %p, got %p", rsp_count, want, rsp_data);
               end
            end
         end
      end
   end

   initial begin : stimulus
      int caps [PHASES] = '{31, 1, 16, 5, 0, 2, 9, 16};
      int gaps [PHASES] = '{30, 20, 0, 40, 25, 10, 35, 0};
      int pool_size;
      logic signed [31:0] k;
      capacity_setting = CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
         cached_valid[i] = 1'b0;
         cached_key[i] = '0;
         cached_value[i] = '0;
         cached_rank[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty cache, extreme keys and values, update of a present key
      gap_pct = 15;
      queue_request(CMD_GET, '0, 32'sh1234_5678);
      queue_request(CMD_PUT, WORD_MIN, WORD_MAX);
      queue_request(CMD_PUT, WORD_MAX, WORD_MIN);
      queue_request(CMD_GET, WORD_MIN, '0);
      queue_request(CMD_PUT, WORD_MAX, '0);
      queue_request(CMD_GET, WORD_MAX, '1);
      queue_request(CMD_PUT, '1, '1);
      queue_request(CMD_GET, 32'sd5, '0);
      queue_request(CMD_GET, '1, '0);
      wait_idle();

      // Capacity lowered below occupancy: new keys replace the oldest entry
      write_capacity(5'd2);
      @(negedge clock);
      queue_request(CMD_PUT, 32'sd9, 32'sd90);
      queue_request(CMD_GET, WORD_MIN, '0);
      queue_request(CMD_PUT, 32'sd10, 32'sd100);
      queue_request(CMD_GET, 32'sd9, '0);
      wait_idle();

      // Zero capacity behaves as one entry
      write_capacity(5'd0);
      @(negedge clock);
      queue_request(CMD_PUT, 32'sd11, 32'sd110);
      queue_request(CMD_PUT, 32'sd12, 32'sd120);
      queue_request(CMD_GET, 32'sd11, '0);
      queue_request(CMD_GET, 32'sd12, '0);
      queue_request(CMD_PUT, 32'sd12, WORD_MIN);
      queue_request(CMD_GET, 32'sd12, '0);
      wait_idle();

      // Random phases over a per-phase key pool sized around the capacity
      for (int p = 0; p < PHASES; p++) begin
         write_capacity(CAP_W'(caps[p]));
         @(negedge clock);
         gap_pct = gaps[p];
         key_pool.delete();
         pool_size = (caps[p] == 0) ? 1 : ((caps[p] > ENTRIES) ? ENTRIES : caps[p]);
         pool_size += $urandom_range(6, 1);
         for (int j = 0; j < pool_size; j++) key_pool.push_back(random_word());
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            if ($urandom_range(9) < 8) k = key_pool[$urandom_range(key_pool.size() - 1)];
            else k = $urandom;
            queue_request(($urandom_range(1) == 1) ? CMD_PUT : CMD_GET, k, random_word());
         end
         wait_idle();
      end

      repeat (8) @(posedge clock);
      mismatches += expected_rsp.size();
      $display("%0d responses checked: %0d hits, %0d evictions", rsp_count, hit_count, evict_count);
      $display("%0d capacity writes, covering zero, one, full and oversize settings", cap_writes);
      if (mismatches == 0) begin
         $display("PASS lru_key_value_cache");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL lru_key_value_cache");
      end
      $finish;
   end

   // Hard stop well past the slowest correct run
   initial begin
      #5_000_000;
      $display("timeout waiting for responses");
      $display("FAIL lru_key_value_cache");
      $finish;
   end

endmodule

`default_nettype wire
